// ----- design/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TDS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tds assertion failed");

// expression must never be true outside reset
`define TDS_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tds forbidden condition seen");

`endif

// ----- design/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg
// Types and constants shared by the task dependency scoreboard files.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int ID_W   = 6;
  localparam int MASK_W = 64;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_START = 2'd1,
    ACT_DONE  = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_READY     = 2'd1,
    ST_RUNNING   = 2'd2,
    ST_COMPLETED = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_DUP = 2'd1,
    STAT_IGN = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic snap;
    logic emit_one;
    logic emit_iss;
  } tds_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e act;
    logic    cmpl_ok;
    logic    iss_any;
    logic    iss_last;
    logic    scan_done;
    logic    out_free;
  } tds_stat_t;

endpackage

// ----- design/tds_if.sv -----
// ----------------------------------------------------------------------------
// tds_req_if / tds_rsp_if
// Valid/ready channels carrying scoreboard requests and results.
// ----------------------------------------------------------------------------
interface tds_req_if import tds_pkg::*; ();
  logic              valid;
  logic              ready;
  action_e           action;
  logic [ID_W-1:0]   task_id;
  logic [MASK_W-1:0] dep_mask;

  modport source (output valid, action, task_id, dep_mask, input ready);
  modport sink   (input valid, action, task_id, dep_mask, output ready);
endinterface

interface tds_rsp_if import tds_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            issue_valid;
  logic [ID_W-1:0] issued_task;
  logic            last;
  status_e         status;
  logic            all_done;

  modport source (output valid, issue_valid, issued_task, last, status, all_done,
                  input ready);
  modport sink   (input valid, issue_valid, issued_task, last, status, all_done,
                  output ready);
endinterface

// ----- design/task_dependency_scoreboard.sv -----
// ----------------------------------------------------------------------------
// task_dependency_scoreboard
// Tracks up to TASK_SLOTS tasks and their dependency masks and issues ready
// tasks in ascending id order. One request is handled at a time. An add, a
// stop or an ignored completion is captured, executed and gives its single
// result once the output is free. A start takes a snapshot of the ready
// tasks and then gives one result per issued task, or a single result when
// nothing is ready. An accepted completion first sweeps the dependency memory
// one slot per cycle through its single read port, then snapshots and issues
// as a start does. A result register sits on the output, so a waiting result
// does not hold up the next request until that request's own result is
// ready.
// ----------------------------------------------------------------------------
module task_dependency_scoreboard import tds_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tds_req_if.sink    req_i,
  tds_rsp_if.source  rsp_o
);

  tds_cmd_t  cmd;
  tds_stat_t stat;

  tds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tds_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (req_i.action),
    .task_id_i     (req_i.task_id),
    .dep_mask_i    (req_i.dep_mask),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .issue_valid_o (rsp_o.issue_valid),
    .issued_task_o (rsp_o.issued_task),
    .last_o        (rsp_o.last),
    .status_o      (rsp_o.status),
    .all_done_o    (rsp_o.all_done)
  );

endmodule

// ----- design/tds_ctrl.sv -----
// ----------------------------------------------------------------------------
// tds_ctrl
// Sequencer: accept, execute, dependency sweep, issue snapshot and result
// emission.
// ----------------------------------------------------------------------------
module tds_ctrl import tds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  tds_stat_t stat_i,
  output tds_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SNAP,
    S_ISSUE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (stat_i.act)
          ACT_ADD:   state_d = S_EMIT;
          ACT_START: state_d = S_SNAP;
          ACT_DONE:  state_d = stat_i.cmpl_ok ? S_SCAN : S_EMIT;
          ACT_STOP:  state_d = S_EMIT;
          default:   state_d = S_EMIT;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_SNAP;
        end
      end
      S_SNAP: begin
        cmd_o.snap = 1'b1;
        state_d    = stat_i.iss_any ? S_ISSUE : S_EMIT;
      end
      S_ISSUE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_iss = 1'b1;
          if (stat_i.iss_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_one = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/tds_dp.sv -----
// ----------------------------------------------------------------------------
// tds_dp
// Slot state, dependency memory, dependency sweep, issue vector and the
// result register.
// ----------------------------------------------------------------------------
module tds_dp import tds_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tds_cmd_t          cmd_i,
  output tds_stat_t         stat_o,
  input  action_e           action_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [MASK_W-1:0] dep_mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              issue_valid_o,
  output logic [ID_W-1:0]   issued_task_o,
  output logic              last_o,
  output status_e           status_o,
  output logic              all_done_o
);

  localparam int IdxW = $clog2(TASK_SLOTS);
  localparam int CntW = $clog2(TASK_SLOTS + 1);

  // captured request
  action_e           act_q;
  logic [ID_W-1:0]   id_q;
  logic [MASK_W-1:0] mask_q;
  status_e           status_q;

  logic [TASK_SLOTS-1:0] present_q, present_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;
  logic [TASK_SLOTS-1:0] iss_q, iss_d;
  slot_state_e           state_q [TASK_SLOTS];
  slot_state_e           state_d [TASK_SLOTS];

  logic [MASK_W-1:0] deps_mem [TASK_SLOTS];
  logic [MASK_W-1:0] rd_q;

  logic [CntW-1:0] scan_cnt_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            chk_vld_q;

  logic            out_vld_q;
  logic            out_iss_q;
  logic [ID_W-1:0] out_task_q;
  logic            out_last_q;
  status_e         out_stat_q;
  logic            out_done_q;

  logic [IdxW-1:0]       idx;
  logic                  in_range;
  logic                  add_ok;
  logic                  cmpl_ok;
  logic                  mask_zero;
  logic [MASK_W-1:0]     cvec;
  logic                  release_hit;
  logic [TASK_SLOTS-1:0] issuable;
  logic [TASK_SLOTS-1:0] low_bit;
  logic [IdxW-1:0]       low_idx;
  logic                  all_done;
  logic                  scan_rd;
  logic                  out_free;
  logic                  out_load;

  assign idx       = id_q[IdxW-1:0];
  assign in_range  = {1'b0, id_q} < (ID_W+1)'(TASK_SLOTS);
  assign add_ok    = in_range && !present_q[idx];
  assign cmpl_ok   = in_range && (state_q[idx] == ST_RUNNING);
  assign mask_zero = (mask_q == '0);

  // completed slots as a dependency vector; ids past the slot count never complete
  for (genvar gi = 0; gi < MASK_W; gi++) begin : g_cvec
    if (gi < TASK_SLOTS) begin : g_in
      assign cvec[gi] = present_q[gi] && (state_q[gi] == ST_COMPLETED);
    end else begin : g_out
      assign cvec[gi] = 1'b0;
    end
  end

  assign release_hit = chk_vld_q && present_q[chk_idx_q] &&
                       (state_q[chk_idx_q] == ST_PENDING) && rd_q[id_q] &&
                       ((rd_q & ~cvec) == '0);

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      issuable[i] = ready_q[i] && (state_q[i] == ST_READY);
    end
  end

  // lowest pending issue, and its index
  assign low_bit = iss_q & (~iss_q + TASK_SLOTS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | IdxW'(i);
      end
    end
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (present_q[i] && (state_q[i] != ST_COMPLETED)) begin
        all_done = 1'b0;
      end
    end
  end

  assign scan_rd  = cmd_i.scan && (scan_cnt_q != CntW'(TASK_SLOTS));
  assign out_free = !out_vld_q || out_ready_i;
  assign out_load = cmd_i.emit_one || cmd_i.emit_iss;

  always_comb begin
    present_d = present_q;
    ready_d   = ready_q;
    iss_d     = iss_q;
    state_d   = state_q;
    if (cmd_i.exec) begin
      unique case (act_q)
        ACT_ADD: begin
          if (add_ok) begin
            present_d[idx] = 1'b1;
            state_d[idx]   = mask_zero ? ST_READY : ST_PENDING;
            ready_d[idx]   = mask_zero;
          end
        end
        ACT_START: ;
        ACT_DONE: begin
          if (cmpl_ok) begin
            state_d[idx] = ST_COMPLETED;
          end
        end
        ACT_STOP: ready_d = '0;
        default: ;
      endcase
    end
    if (release_hit) begin
      state_d[chk_idx_q] = ST_READY;
      ready_d[chk_idx_q] = 1'b1;
    end
    if (cmd_i.snap) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (issuable[i]) begin
          state_d[i] = ST_RUNNING;
        end
      end
      iss_d   = issuable;
      ready_d = '0;
    end
    if (cmd_i.emit_iss) begin
      iss_d = iss_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      ready_q    <= '0;
      iss_q      <= '0;
      scan_cnt_q <= '0;
      chk_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        state_q[i] <= ST_PENDING;
      end
    end else begin
      present_q <= present_d;
      ready_q   <= ready_d;
      iss_q     <= iss_d;
      state_q   <= state_d;
      if (cmd_i.exec) begin
        scan_cnt_q <= '0;
      end else if (scan_rd) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      chk_vld_q <= scan_rd;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      id_q   <= task_id_i;
      mask_q <= dep_mask_i;
    end
    if (cmd_i.exec) begin
      if (act_q == ACT_ADD && !add_ok) begin
        status_q <= STAT_DUP;
      end else if (act_q == ACT_DONE && !cmpl_ok) begin
        status_q <= STAT_IGN;
      end else begin
        status_q <= STAT_OK;
      end
    end
    if (scan_rd) begin
      chk_idx_q <= scan_cnt_q[IdxW-1:0];
    end
    if (out_load) begin
      out_iss_q  <= cmd_i.emit_iss;
      out_task_q <= cmd_i.emit_iss ? ID_W'(low_idx) : '0;
      out_last_q <= cmd_i.emit_one || ((iss_q & ~low_bit) == '0);
      out_stat_q <= status_q;
      out_done_q <= all_done;
    end
  end

  // dependency memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && act_q == ACT_ADD && add_ok) begin
      deps_mem[idx] <= mask_q;
    end
    if (scan_rd) begin
      rd_q <= deps_mem[scan_cnt_q[IdxW-1:0]];
    end
  end

  assign stat_o.act       = act_q;
  assign stat_o.cmpl_ok   = cmpl_ok;
  assign stat_o.iss_any   = |issuable;
  assign stat_o.iss_last  = ((iss_q & ~low_bit) == '0);
  assign stat_o.scan_done = (scan_cnt_q == CntW'(TASK_SLOTS)) && !chk_vld_q;
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_vld_q;
  assign issue_valid_o = out_iss_q;
  assign issued_task_o = out_task_q;
  assign last_o        = out_last_q;
  assign status_o      = out_stat_q;
  assign all_done_o    = out_done_q;

endmodule

// ----- design/tds_checker.sv -----
// ----------------------------------------------------------------------------
// tds_checker
// Port-level checks on the scoreboard result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tds_checker import tds_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            issue_valid_i,
  input logic [ID_W-1:0] issued_task_i,
  input logic            last_i,
  input logic [1:0]      status_i,
  input logic            all_done_i
);

  // a stalled result stays put
  `TDS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `TDS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable({issue_valid_i, issued_task_i, last_i, status_i, all_done_i}))

  // a non-issuing result is always the only one of its request
  `TDS_ASSERT(a_idle_result, clk_i, rst_ni, out_valid_i && !issue_valid_i |-> last_i && issued_task_i == '0)

  // an issued task is running, so nothing can be all done
  `TDS_NEVER(a_issue_done, clk_i, rst_ni, out_valid_i && issue_valid_i && (all_done_i || status_i != STAT_OK))

endmodule

bind task_dependency_scoreboard tds_checker u_tds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .issue_valid_i (rsp_o.issue_valid),
  .issued_task_i (rsp_o.issued_task),
  .last_i        (rsp_o.last),
  .status_i      (rsp_o.status),
  .all_done_i    (rsp_o.all_done)
);
